/* design/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, held off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// implication a |-> b on the same edge
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons))

// implication a |=> b on the following edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons))

`endif

/* design/lsp_pkg.sv */
// types and constants for the lsb stego pixel stream block
// no dependencies
package lsp_pkg;

    // pixels in the length header at the start of each frame
    localparam int unsigned HeaderPixels = 8;
    // width of the per-frame pixel counter
    localparam int unsigned CountW = 34;
    // width of the payload length
    localparam int unsigned LenW = 32;

    // operating mode
    typedef enum logic {
        MODE_EMBED   = 1'b0,
        MODE_EXTRACT = 1'b1
    } t_mode;

    // configuration register indexes
    typedef enum logic {
        CFG_MODE   = 1'b0,
        CFG_LENGTH = 1'b1
    } t_cfg_idx;

    // one input beat
    typedef struct packed {
        logic       frame_start;
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] payload_byte;
    } t_pixel;

    // one result beat
    typedef struct packed {
        logic [7:0]      alpha;
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
        logic            byte_valid;
        logic [7:0]      recovered_byte;
        logic            last_byte;
        logic            length_valid;
        logic [LenW-1:0] recovered_length;
    } t_result;

endpackage

/* design/lsp_in_stage.sv */
// input register of the pixel stream block
// depends on lsp_pkg
module lsp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lsp_pkg::t_pixel   i_pixel,
    input  logic              i_pop,
    output logic              o_stall,
    output logic              o_valid,
    output lsp_pkg::t_pixel   o_pixel
);

    logic            r_valid;
    logic            n_valid;
    lsp_pkg::t_pixel r_pixel;
    logic            load;

    // take a new beat whenever the register is empty or being emptied
    assign o_stall = r_valid && !i_pop;
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload holds no reset
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pixel <= i_pixel;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

endmodule

/* design/lsp_core.sv */
// per-pixel embed and extract logic with the frame state registers
// depends on lsp_pkg
module lsp_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsp_pkg::t_mode                i_mode,
    input  logic [lsp_pkg::LenW-1:0]      i_payload_length,
    input  logic                          i_advance,
    input  lsp_pkg::t_pixel               i_pixel,
    output lsp_pkg::t_result              o_result
);

    localparam int unsigned CW = lsp_pkg::CountW;
    localparam int unsigned LW = lsp_pkg::LenW;

    logic [CW-1:0] r_pixel_count;
    logic [7:0]    r_held_byte;
    logic [3:0]    r_low_nibble;
    logic [LW-1:0] r_header_length;

    logic [CW-1:0] n_pixel_count;
    logic [7:0]    n_held_byte;
    logic [3:0]    n_low_nibble;
    logic [LW-1:0] n_header_length;

    logic [CW-1:0] idx;
    logic [CW-1:0] d;
    logic [CW-1:0] embed_lim;
    logic [CW-1:0] extract_lim;
    logic [4:0]    nib_pos;
    logic          is_header;
    logic          even;
    logic [3:0]    nib_in;
    logic [3:0]    nib_out;
    logic          touch;
    logic [7:0]    held_eff;
    logic [3:0]    low_eff;
    logic [LW-1:0] hlen_eff;
    lsp_pkg::t_result res;

    always_comb begin
        // frame start restarts the count and clears the per-frame state
        idx      = i_pixel.frame_start ? '0 : r_pixel_count;
        held_eff = i_pixel.frame_start ? '0 : r_held_byte;
        low_eff  = i_pixel.frame_start ? '0 : r_low_nibble;
        hlen_eff = i_pixel.frame_start ? '0 : r_header_length;

        is_header   = (idx[CW-1:3] == '0);
        nib_pos     = {idx[2:0], 2'b00};
        even        = ~idx[0];
        d           = idx - CW'(lsp_pkg::HeaderPixels);
        embed_lim   = {1'b0, i_payload_length, 1'b0};
        extract_lim = {1'b0, hlen_eff, 1'b0};
        nib_in      = {i_pixel.blue[0], i_pixel.green[0], i_pixel.red[0], i_pixel.alpha[0]};

        n_held_byte     = held_eff;
        n_low_nibble    = low_eff;
        n_header_length = hlen_eff;
        nib_out         = '0;
        touch           = 1'b0;

        res                  = '0;
        res.alpha            = i_pixel.alpha;
        res.red              = i_pixel.red;
        res.green            = i_pixel.green;
        res.blue             = i_pixel.blue;

        case (i_mode)
            lsp_pkg::MODE_EMBED: begin
                // header nibbles from the length register, then payload bytes
                if (is_header) begin
                    nib_out = i_payload_length[nib_pos +: 4];
                    touch   = 1'b1;
                end else if (d < embed_lim) begin
                    if (even) begin
                        n_held_byte = i_pixel.payload_byte;
                        nib_out     = i_pixel.payload_byte[3:0];
                    end else begin
                        nib_out = held_eff[7:4];
                    end
                    touch = 1'b1;
                end
                if (touch) begin
                    res.alpha = {i_pixel.alpha[7:1], nib_out[0]};
                    res.red   = {i_pixel.red[7:1], nib_out[1]};
                    res.green = {i_pixel.green[7:1], nib_out[2]};
                    res.blue  = {i_pixel.blue[7:1], nib_out[3]};
                end
            end
            lsp_pkg::MODE_EXTRACT: begin
                // rebuild the length, then pair nibbles into bytes
                if (is_header) begin
                    n_header_length[nib_pos +: 4] = nib_in;
                end else if (d < extract_lim) begin
                    if (even) begin
                        n_low_nibble = nib_in;
                    end else begin
                        res.byte_valid     = 1'b1;
                        res.recovered_byte = {nib_in, low_eff};
                        res.last_byte      = (d[CW-1:1] == ({1'b0, hlen_eff} - (LW+1)'(1)));
                    end
                end
                if (!(is_header && (idx[2:0] != 3'd7))) begin
                    res.length_valid     = 1'b1;
                    res.recovered_length = n_header_length;
                end
            end
            default: begin
                touch = 1'b0;
            end
        endcase

        // counter saturates at all ones
        n_pixel_count = (&idx) ? idx : idx + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count   <= '0;
            r_held_byte     <= '0;
            r_low_nibble    <= '0;
            r_header_length <= '0;
        end else if (i_advance) begin
            r_pixel_count   <= n_pixel_count;
            r_held_byte     <= n_held_byte;
            r_low_nibble    <= n_low_nibble;
            r_header_length <= n_header_length;
        end
    end

    assign o_result = res;

endmodule

/* design/lsp_out_stage.sv */
// result register of the pixel stream block
// depends on lsp_pkg
module lsp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lsp_pkg::t_result  i_result,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output lsp_pkg::t_result  o_result
);

    logic             r_valid;
    logic             n_valid;
    lsp_pkg::t_result r_result;

    // free when empty or when the held beat leaves this edge
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* design/lsb_stego_pixel_stream_unit.sv */
// lsb stego pixel stream unit: hides or recovers four bits per argb pixel
// the input channel carries one pixel a beat with the payload byte to embed;
// the output channel carries the pixel after embedding, or passed through,
// with any extracted byte and the decoded header length.
// a configuration write port sets the mode (embed or extract) and the
// payload length; the user must write it only while the block is idle,
// which the block itself does not enforce.
// throughput: one pixel a clock while the receiver does not stall, set by
// the input register and the result register on either side of the
// combinational embed and extract logic.
// a beat is accepted while an earlier result still waits at the output.
// when the receiver stalls the result holds; the input register still takes
// one more beat, then the input is stalled until the output moves.
// reset (synchronous, active low) empties both registers, sets embed mode,
// length zero, and restarts pixel counting at the first pixel.
// frame start on a beat restarts counting at that pixel.
// depends on lsp_pkg, lsp_in_stage, lsp_core, lsp_out_stage
module lsb_stego_pixel_stream_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_frame_start,
    input  logic [7:0]  i_alpha,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_payload_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_alpha,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic        o_byte_valid,
    output logic [7:0]  o_recovered_byte,
    output logic        o_last_byte,
    output logic        o_length_valid,
    output logic [31:0] o_recovered_length
);

    lsp_pkg::t_mode              r_mode;
    logic [lsp_pkg::LenW-1:0]    r_payload_length;
    lsp_pkg::t_pixel             in_pixel;
    lsp_pkg::t_pixel             stage_pixel;
    logic                        stage_valid;
    logic                        out_free;
    logic                        advance;
    lsp_pkg::t_result            core_result;
    lsp_pkg::t_result            out_result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= lsp_pkg::MODE_EMBED;
            r_payload_length <= '0;
        end else if (i_cfg_we) begin
            case (lsp_pkg::t_cfg_idx'(i_cfg_idx))
                lsp_pkg::CFG_MODE: begin
                    r_mode <= lsp_pkg::t_mode'(i_cfg_data[0]);
                end
                lsp_pkg::CFG_LENGTH: begin
                    r_payload_length <= i_cfg_data;
                end
                default: begin
                    r_mode <= r_mode;
                end
            endcase
        end
    end

    assign in_pixel = '{
        frame_start:  i_frame_start,
        alpha:        i_alpha,
        red:          i_red,
        green:        i_green,
        blue:         i_blue,
        payload_byte: i_payload_byte
    };

    // pixel moves from input register to result register
    assign advance = stage_valid && out_free;

    lsp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_pixel (in_pixel),
        .i_pop   (advance),
        .o_stall (o_in_stall),
        .o_valid (stage_valid),
        .o_pixel (stage_pixel)
    );

    lsp_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mode           (r_mode),
        .i_payload_length (r_payload_length),
        .i_advance        (advance),
        .i_pixel          (stage_pixel),
        .o_result         (core_result)
    );

    lsp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_out_alpha        = out_result.alpha;
    assign o_out_red          = out_result.red;
    assign o_out_green        = out_result.green;
    assign o_out_blue         = out_result.blue;
    assign o_byte_valid       = out_result.byte_valid;
    assign o_recovered_byte   = out_result.recovered_byte;
    assign o_last_byte        = out_result.last_byte;
    assign o_length_valid     = out_result.length_valid;
    assign o_recovered_length = out_result.recovered_length;

endmodule

/* design/lsp_checker.sv */
// port-level checks for the lsb stego pixel stream unit, with its bind
// depends on assert_macros.svh and lsb_stego_pixel_stream_unit
`include "assert_macros.svh"

module lsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_out_alpha,
    input logic [7:0]  o_out_blue,
    input logic        o_byte_valid,
    input logic [7:0]  o_recovered_byte,
    input logic        o_last_byte,
    input logic        o_length_valid,
    input logic [31:0] o_recovered_length
);

    // an extracted byte only follows a complete header
    `ASSERT_IMPLIES(a_byte_after_len, i_clk, i_rst_n,
        o_out_valid && o_byte_valid, o_length_valid)

    // last byte flag only rides with a byte
    `ASSERT_IMPLIES(a_last_with_byte, i_clk, i_rst_n,
        o_out_valid && o_last_byte, o_byte_valid)

    // no byte beat shows zero byte fields
    `ASSERT_IMPLIES(a_idle_byte_zero, i_clk, i_rst_n, o_out_valid && !o_byte_valid,
        (o_recovered_byte == 8'd0) && !o_last_byte)

    // length reads zero until the header is in
    `ASSERT_IMPLIES(a_len_zero, i_clk, i_rst_n,
        o_out_valid && !o_length_valid, o_recovered_length == 32'd0)

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_alpha) && $stable(o_out_blue) && $stable(o_recovered_length))

endmodule

bind lsb_stego_pixel_stream_unit lsp_checker u_lsp_checker (.*);

/* bench/lsb_stego_pixel_stream_unit_test.sv */
// self-checking bench for lsb_stego_pixel_stream_unit: directed and random pixel frames
// in embed and extract mode, checked beat by beat against an in-bench predictor
// depends on lsp_pkg and lsb_stego_pixel_stream_unit
`timescale 1ns / 100ps

module lsb_stego_pixel_stream_unit_test;

    // scoreboard: predicts each output pixel and checks the beats that come back
    class pixel_scoreboard;
        lsp_pkg::t_mode                 mode;
        logic [lsp_pkg::LenW-1:0]       embed_len;
        logic [lsp_pkg::CountW-1:0]     pix_idx;
        logic [7:0]                     held_byte;
        logic [3:0]                     low_nib;
        logic [lsp_pkg::LenW-1:0]       hdr_len;
        lsp_pkg::t_result               expected_pixels[$];
        int                             mismatches;
        int                             frames_seen;
        int                             bytes_seen;
        int                             last_seen;

        function new();
            mode = lsp_pkg::MODE_EMBED;
            embed_len = '0;
            pix_idx = '0;
            held_byte = '0;
            low_nib = '0;
            hdr_len = '0;
            mismatches = 0;
            frames_seen = 0;
            bytes_seen = 0;
            last_seen = 0;
        endfunction

        function void set_reg(lsp_pkg::t_cfg_idx idx, logic [31:0] value);
            if (idx == lsp_pkg::CFG_MODE) begin
                mode = lsp_pkg::t_mode'(value[0]);
            end else begin
                embed_len = value;
            end
        endfunction

        // work out the result of one accepted pixel and queue it
        function void note_pixel(lsp_pkg::t_pixel p);
            lsp_pkg::t_result               r;
            logic [3:0]                     nib;
            logic [lsp_pkg::CountW-1:0]     d;
            logic [lsp_pkg::CountW:0]       span;
            logic                           touch;
            if (p.frame_start) begin
                pix_idx = '0;
                held_byte = '0;
                low_nib = '0;
                hdr_len = '0;
                frames_seen++;
            end
            r = '0;
            r.alpha = p.alpha;
            r.red = p.red;
            r.green = p.green;
            r.blue = p.blue;
            touch = 1'b0;
            nib = '0;
            d = pix_idx - lsp_pkg::CountW'(lsp_pkg::HeaderPixels);
            if (mode == lsp_pkg::MODE_EMBED) begin
                span = (lsp_pkg::CountW+1)'({embed_len, 1'b0});
                if (pix_idx < lsp_pkg::CountW'(lsp_pkg::HeaderPixels)) begin
                    nib = embed_len[{pix_idx[2:0], 2'b00} +: 4];
                    touch = 1'b1;
                end else if ((lsp_pkg::CountW+1)'(d) < span) begin
                    // even data pixel takes the byte, odd one uses the held high nibble
                    if (!d[0]) begin
                        held_byte = p.payload_byte;
                        nib = p.payload_byte[3:0];
                    end else begin
                        nib = held_byte[7:4];
                    end
                    touch = 1'b1;
                end
                if (touch) begin
                    r.alpha[0] = nib[0];
                    r.red[0] = nib[1];
                    r.green[0] = nib[2];
                    r.blue[0] = nib[3];
                end
            end else begin
                nib = {p.blue[0], p.green[0], p.red[0], p.alpha[0]};
                if (pix_idx < lsp_pkg::CountW'(lsp_pkg::HeaderPixels)) begin
                    hdr_len[{pix_idx[2:0], 2'b00} +: 4] = nib;
                end else begin
                    span = (lsp_pkg::CountW+1)'({hdr_len, 1'b0});
                    if ((lsp_pkg::CountW+1)'(d) < span) begin
                        if (!d[0]) begin
                            low_nib = nib;
                        end else begin
                            r.byte_valid = 1'b1;
                            r.recovered_byte = {nib, low_nib};
                            r.last_byte = ((d >> 1) ==
                                lsp_pkg::CountW'(hdr_len) - lsp_pkg::CountW'(1));
                            bytes_seen++;
                            if (r.last_byte) begin
                                last_seen++;
                            end
                        end
                    end
                end
                if (pix_idx >= lsp_pkg::CountW'(lsp_pkg::HeaderPixels - 1)) begin
                    r.length_valid = 1'b1;
                    r.recovered_length = hdr_len;
                end
            end
            // counter saturates at all ones
            if (pix_idx != '1) begin
                pix_idx++;
            end
            expected_pixels.push_back(r);
        endfunction

        function void flag(string what, lsp_pkg::t_result want, lsp_pkg::t_result got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t %s", $realtime, what);
                $display("  want a=%02h r=%02h g=%02h b=%02h byte=%0b/%02h last=%0b len=%0b/%08h",
                         want.alpha, want.red, want.green, want.blue,
                         want.byte_valid, want.recovered_byte, want.last_byte,
                         want.length_valid, want.recovered_length);
                $display("  got  a=%02h r=%02h g=%02h b=%02h byte=%0b/%02h last=%0b len=%0b/%08h",
                         got.alpha, got.red, got.green, got.blue,
                         got.byte_valid, got.recovered_byte, got.last_byte,
                         got.length_valid, got.recovered_length);
            end
        endfunction

        // compare one output beat with the oldest prediction
        function void check_result(lsp_pkg::t_result got);
            lsp_pkg::t_result want;
            if (expected_pixels.size() == 0) begin
                flag("output beat with nothing pending", '0, got);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.alpha !== want.alpha || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue ||
                got.byte_valid !== want.byte_valid ||
                got.recovered_byte !== want.recovered_byte ||
                got.last_byte !== want.last_byte ||
                got.length_valid !== want.length_valid ||
                got.recovered_length !== want.recovered_length) begin
                flag("output beat mismatch", want, got);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_frame_start = 1'b0;
    logic [7:0]  i_alpha = '0;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic [7:0]  i_payload_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_alpha;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic        o_byte_valid;
    logic [7:0]  o_recovered_byte;
    logic        o_last_byte;
    logic        o_length_valid;
    logic [31:0] o_recovered_length;

    pixel_scoreboard sb = new();
    int send_idle_pct = 30;
    int recv_stall_pct = 79;
    int pixels_sent = 0;
    int embed_settings = 0;
    int extract_settings = 0;

    lsb_stego_pixel_stream_unit dut (.*);

    // clock
    always #1 i_clk = ~i_clk;

    // run limit
    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // output side: check accepted beats, stall at random
    always @(posedge i_clk) begin
        lsp_pkg::t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.alpha = o_out_alpha;
            got.red = o_out_red;
            got.green = o_out_green;
            got.blue = o_out_blue;
            got.byte_valid = o_byte_valid;
            got.recovered_byte = o_recovered_byte;
            got.last_byte = o_last_byte;
            got.length_valid = o_length_valid;
            got.recovered_length = o_recovered_length;
            sb.check_result(got);
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic lsp_pkg::t_pixel rand_pixel();
        lsp_pkg::t_pixel p;
        p.frame_start = 1'b0;
        p.alpha = 8'($urandom);
        p.red = 8'($urandom);
        p.green = 8'($urandom);
        p.blue = 8'($urandom);
        p.payload_byte = 8'($urandom);
        return p;
    endfunction

    function automatic lsp_pkg::t_pixel hide_nibble(lsp_pkg::t_pixel p, logic [3:0] nib);
        p.alpha[0] = nib[0];
        p.red[0] = nib[1];
        p.green[0] = nib[2];
        p.blue[0] = nib[3];
        return p;
    endfunction

    function automatic logic [31:0] pick_length();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return 32'($urandom_range(1, 6));
        endcase
    endfunction

    // one input beat, with random idle cycles ahead of it
    task automatic send_pixel(lsp_pkg::t_pixel p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_frame_start <= p.frame_start;
        i_alpha <= p.alpha;
        i_red <= p.red;
        i_green <= p.green;
        i_blue <= p.blue;
        i_payload_byte <= p.payload_byte;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(p);
        pixels_sent++;
    endtask

    // hold the input until every pending beat has come out
    task automatic pause_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(lsp_pkg::t_cfg_idx idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // frame of random pixels with a length header hidden in the first eight
    task automatic send_frame(logic [31:0] hdr, int n_pix, bit with_start, bit noisy);
        lsp_pkg::t_pixel p;
        for (int k = 0; k < n_pix; k++) begin
            p = rand_pixel();
            p.frame_start = (k == 0) && with_start;
            if (k < lsp_pkg::HeaderPixels && !(noisy && $urandom_range(99) < 3)) begin
                p = hide_nibble(p, hdr[4*k +: 4]);
            end
            // broken frame: restart in the middle
            if (noisy && $urandom_range(99) < 4) begin
                p.frame_start = 1'b1;
            end
            send_pixel(p);
        end
    endtask

    // new register setting, then a few frames; the first may carry on the old frame
    task automatic run_setting();
        lsp_pkg::t_mode m;
        logic [31:0]    len;
        logic [31:0]    hdr;
        logic [31:0]    eff;
        int             frames;
        int             n_pix;
        bit             restart;
        pause_for_results();
        m = lsp_pkg::t_mode'($urandom_range(1));
        len = pick_length();
        write_reg(lsp_pkg::CFG_MODE, 32'(m));
        write_reg(lsp_pkg::CFG_LENGTH, len);
        if (m == lsp_pkg::MODE_EMBED) begin
            embed_settings++;
        end else begin
            extract_settings++;
        end
        restart = ($urandom_range(3) != 0);
        frames = $urandom_range(1, 4);
        for (int f = 0; f < frames; f++) begin
            hdr = pick_length();
            eff = (m == lsp_pkg::MODE_EMBED) ? len : hdr;
            n_pix = lsp_pkg::HeaderPixels + 2 * ((eff > 12) ? 12 : int'(eff))
                    + $urandom_range(0, 3);
            if ($urandom_range(9) == 0) begin
                n_pix = $urandom_range(1, n_pix);
            end
            send_frame(hdr, n_pix, restart || f > 0, 1'b1);
        end
    endtask

    // stimulus
    initial begin
        lsp_pkg::t_pixel p;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no frame start after reset, embed mode with zero length
        p = '{frame_start: 1'b0, alpha: 8'hFF, red: 8'hFF, green: 8'hFF, blue: 8'hFF,
              payload_byte: 8'hFF};
        send_pixel(p);
        p = '{frame_start: 1'b0, alpha: 8'h00, red: 8'h00, green: 8'h00, blue: 8'h00,
              payload_byte: 8'h00};
        send_pixel(p);

        // embed two bytes, extreme channel values, one pixel past the payload
        pause_for_results();
        write_reg(lsp_pkg::CFG_LENGTH, 32'd2);
        for (int k = 0; k < 13; k++) begin
            p.frame_start = (k == 0);
            p.alpha = k[0] ? 8'hFF : 8'h00;
            p.red = k[0] ? 8'h00 : 8'hFF;
            p.green = k[0] ? 8'hFF : 8'h00;
            p.blue = k[0] ? 8'h00 : 8'hFF;
            p.payload_byte = (k % 4 == 0) ? 8'hFF : 8'h00;
            send_pixel(p);
        end

        // extract a one-byte payload, last byte marked
        pause_for_results();
        write_reg(lsp_pkg::CFG_MODE, 32'(lsp_pkg::MODE_EXTRACT));
        send_frame(32'd1, 11, 1'b1, 1'b0);

        // random settings and frames under three idle patterns
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 30; recv_stall_pct = 79; end
                1: begin send_idle_pct = 79; recv_stall_pct = 30; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            while (pixels_sent < 26 + 500 * (phase + 1)) begin
                run_setting();
            end
        end

        pause_for_results();
        $display("covered %0d pixels in %0d frames, %0d embed and %0d extract settings",
                 pixels_sent, sb.frames_seen, embed_settings, extract_settings);
        $display("extracted %0d bytes, %0d of them last; %0d mismatches",
                 sb.bytes_seen, sb.last_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
